// ===== rtl/fsre_pkg.sv =====
package fsre_pkg;

    // Field widths of the byte stream.
    localparam int SYM_W        = 8;
    localparam int SYM_COUNT    = 256;
    localparam int IN_TDATA_W   = 32;
    localparam int OUT_TDATA_W  = 8;

    // Longest run absorbed before the count code is sent.
    localparam int MAX_REPEAT_DEF = 254;

    // Depth of the decision queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Item kinds carried in s_tuser.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DATA = 1'b1;

    // Bit positions of the input tdata fields.
    localparam int TD_INDEX_LSB = 0;
    localparam int TD_ENABLE    = 8;
    localparam int TD_CODE_LSB  = 9;
    localparam int TD_DATA_LSB  = 17;

    // Piece order within one entry: close code, literal, zero-count code.
    localparam int PIECE_CLOSE = 0;
    localparam int PIECE_LIT   = 1;
    localparam int PIECE_ZERO  = 2;

    typedef logic [SYM_W-1:0] sym_t;

    // One decided data item: the bytes it sends, in piece order.
    typedef struct packed {
        logic has_close;
        logic has_lit;
        logic has_zero;
        logic is_final;
        sym_t close_code;
        sym_t lit;
        sym_t zero_code;
    } fsre_entry_t;

endpackage

// ===== rtl/flagged_symbol_run_encoder.sv =====
// Channel | Signals                        | Beat contents
// --------+--------------------------------+-----------------------------------------------
// input   | s_tvalid s_tready s_tdata      | table_index, run_enable_bit, code_value,
//         | s_tuser s_tlast                | data_byte in tdata; cmd in tuser; final_byte
// output  | m_tvalid m_tready m_tdata      | out_byte in tdata; last_of_item in tlast;
//         | m_tuser m_tlast                | stream_done in tuser
//
// One input beat is taken per cycle while s_tready is high. A data byte that sends k
// output bytes (k is 0 to 3) holds the output serializer until all of them are sent; the
// two-entry queue absorbs short bursts. Beats pass stage 1, stage 2, queue, output register.
// Reset clears the run-enable table and run state at once; code entries are undefined
// until loaded. Either side may stall independently of the other.
module flagged_symbol_run_encoder #(
    parameter int MAX_REPEAT = fsre_pkg::MAX_REPEAT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // table_index[7:0], run_enable_bit[8], code_value[16:9], data_byte[24:17], zero fill
    input  logic [fsre_pkg::IN_TDATA_W-1:0]  s_tdata,
    // cmd[0]
    input  logic                             s_tuser,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // out_byte[7:0]
    output logic [fsre_pkg::OUT_TDATA_W-1:0] m_tdata,
    // stream_done[0]
    output logic                             m_tuser,
    output logic                             m_tlast
);

    logic                  push_valid;
    logic                  push_ready;
    fsre_pkg::fsre_entry_t push_entry;
    logic                  head_valid;
    logic                  head_pop;
    fsre_pkg::fsre_entry_t head_entry;

    // Front: table lookups and run decisions.
    fsre_front #(
        .MAX_REPEAT (MAX_REPEAT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    // Decision queue.
    fsre_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (head_valid),
        .pop_ready  (head_pop),
        .pop_entry  (head_entry)
    );

    // Back: byte serializer and output register.
    fsre_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .head_entry (head_entry),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

// ===== rtl/fsre_front.sv =====
module fsre_front #(
    parameter int MAX_REPEAT = fsre_pkg::MAX_REPEAT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // table_index[7:0], run_enable_bit[8], code_value[16:9], data_byte[24:17], zero fill
    input  logic [fsre_pkg::IN_TDATA_W-1:0] s_tdata,
    // cmd[0]
    input  logic                           s_tuser,
    input  logic                           s_tlast,
    output logic                           push_valid,
    input  logic                           push_ready,
    output fsre_pkg::fsre_entry_t          push_entry
);

    // Input decode.
    logic           accept;
    logic           is_data;
    fsre_pkg::sym_t in_index;
    fsre_pkg::sym_t in_code;
    fsre_pkg::sym_t in_byte;
    logic           in_enable;

    assign accept    = s_tvalid && s_tready;
    assign is_data   = (s_tuser == fsre_pkg::CMD_DATA);
    assign in_index  = s_tdata[fsre_pkg::TD_INDEX_LSB +: fsre_pkg::SYM_W];
    assign in_code   = s_tdata[fsre_pkg::TD_CODE_LSB +: fsre_pkg::SYM_W];
    assign in_byte   = s_tdata[fsre_pkg::TD_DATA_LSB +: fsre_pkg::SYM_W];
    assign in_enable = s_tdata[fsre_pkg::TD_ENABLE];

    // Tables.
    logic           en_table_reg   [fsre_pkg::SYM_COUNT];
    fsre_pkg::sym_t code_table_reg [fsre_pkg::SYM_COUNT];

    // Stage 1: data byte with its run-enable flag.
    logic           s1_valid_reg;
    fsre_pkg::sym_t s1_byte_reg;
    logic           s1_fin_reg;
    logic           s1_en_reg;

    // Stage 2: decision with the code bytes read from the table.
    logic           s2_valid_reg;
    logic           s2_valid_next;
    logic           s2_close_reg;
    logic           s2_lit_reg;
    logic           s2_zero_reg;
    logic           s2_fin_reg;
    fsre_pkg::sym_t s2_byte_reg;
    fsre_pkg::sym_t rd_close_reg;
    fsre_pkg::sym_t rd_zero_reg;

    // Run state.
    logic           run_open_reg;
    logic           run_open_next;
    fsre_pkg::sym_t run_sym_reg;
    fsre_pkg::sym_t run_sym_next;
    fsre_pkg::sym_t count_reg;
    fsre_pkg::sym_t count_next;

    // Decision terms.
    logic           s2_free;
    logic           s1_adv;
    logic           match;
    fsre_pkg::sym_t count_inc;
    logic           run_full;
    logic           emit;
    logic           dec_close;
    logic           dec_lit;
    logic           dec_zero;
    fsre_pkg::sym_t close_addr;

    assign s2_free  = !s2_valid_reg || push_ready;
    assign s1_adv   = s1_valid_reg && s2_free;
    assign s_tready = !s1_valid_reg || s2_free;

    // Classify the byte against the open run.
    always_comb
    begin
        match     = run_open_reg && !s1_fin_reg && (s1_byte_reg == run_sym_reg);
        count_inc = count_reg + fsre_pkg::sym_t'(1);
        run_full  = (count_inc >= fsre_pkg::sym_t'(MAX_REPEAT));
        if (match)
        begin
            dec_close  = run_full;
            dec_lit    = 1'b0;
            dec_zero   = 1'b0;
            close_addr = count_inc;
        end
        else
        begin
            dec_close  = run_open_reg;
            dec_lit    = 1'b1;
            dec_zero   = s1_en_reg && s1_fin_reg;
            close_addr = count_reg;
        end
        emit = dec_close || dec_lit;
    end

    // Next run state.
    always_comb
    begin
        run_open_next = run_open_reg;
        run_sym_next  = run_sym_reg;
        count_next    = count_reg;
        if (match)
        begin
            if (run_full)
            begin
                run_open_next = 1'b0;
                count_next    = '0;
            end
            else
            begin
                count_next = count_inc;
            end
        end
        else if (s1_fin_reg)
        begin
            run_open_next = 1'b0;
            run_sym_next  = '0;
            count_next    = '0;
        end
        else if (s1_en_reg)
        begin
            run_open_next = 1'b1;
            run_sym_next  = s1_byte_reg;
            count_next    = '0;
        end
        else
        begin
            run_open_next = 1'b0;
            count_next    = '0;
        end
    end

    // Stage 2 occupancy.
    always_comb
    begin
        if (s1_adv)
            s2_valid_next = emit;
        else if (push_ready)
            s2_valid_next = 1'b0;
        else
            s2_valid_next = s2_valid_reg;
    end

    // Run-enable table with stage 1 read; loads write in accept order.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fsre_pkg::SYM_COUNT; i++)
                en_table_reg[i] <= 1'b0;
            s1_en_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (is_data)
                s1_en_reg <= en_table_reg[in_byte];
            else
                en_table_reg[in_index] <= in_enable;
        end
    end

    // Count-code table; the read for a byte happens as it leaves stage 1.
    always_ff @(posedge clk)
    begin
        if (accept && !is_data)
            code_table_reg[in_index] <= in_code;
        if (s1_adv)
        begin
            rd_close_reg <= code_table_reg[close_addr];
            rd_zero_reg  <= code_table_reg[0];
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            run_open_reg <= 1'b0;
            run_sym_reg  <= '0;
            count_reg    <= '0;
        end
        else
        begin
            if (accept && is_data)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
            s2_valid_reg <= s2_valid_next;
            if (s1_adv)
            begin
                run_open_reg <= run_open_next;
                run_sym_reg  <= run_sym_next;
                count_reg    <= count_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept && is_data)
        begin
            s1_byte_reg <= in_byte;
            s1_fin_reg  <= s_tlast;
        end
        if (s1_adv)
        begin
            s2_close_reg <= dec_close;
            s2_lit_reg   <= dec_lit;
            s2_zero_reg  <= dec_zero;
            s2_fin_reg   <= s1_fin_reg && !match;
            s2_byte_reg  <= s1_byte_reg;
        end
    end

    assign push_valid            = s2_valid_reg;
    assign push_entry.has_close  = s2_close_reg;
    assign push_entry.has_lit    = s2_lit_reg;
    assign push_entry.has_zero   = s2_zero_reg;
    assign push_entry.is_final   = s2_fin_reg;
    assign push_entry.close_code = rd_close_reg;
    assign push_entry.lit        = s2_byte_reg;
    assign push_entry.zero_code  = rd_zero_reg;

endmodule

// ===== rtl/fsre_queue.sv =====
module fsre_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  fsre_pkg::fsre_entry_t push_entry,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output fsre_pkg::fsre_entry_t pop_entry
);

    fsre_pkg::fsre_entry_t             slot_reg [fsre_pkg::QUEUE_DEPTH];
    logic [fsre_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [fsre_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [fsre_pkg::QCNT_W-1:0]       fill_reg;
    logic                              do_push;
    logic                              do_pop;

    assign push_ready = (fill_reg != fsre_pkg::QCNT_W'(fsre_pkg::QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_entry  = slot_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == fsre_pkg::QPTR_W'(fsre_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + fsre_pkg::QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == fsre_pkg::QPTR_W'(fsre_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + fsre_pkg::QPTR_W'(1);
            if (do_push && !do_pop)
                fill_reg <= fill_reg + fsre_pkg::QCNT_W'(1);
            else if (do_pop && !do_push)
                fill_reg <= fill_reg - fsre_pkg::QCNT_W'(1);
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

// ===== rtl/fsre_back.sv =====
module fsre_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             head_valid,
    output logic                             head_pop,
    input  fsre_pkg::fsre_entry_t            head_entry,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // out_byte[7:0]
    output logic [fsre_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                             m_tlast,
    // stream_done[0]
    output logic                             m_tuser
);

    logic [2:0]     done_reg;
    logic [2:0]     pending;
    logic [2:0]     pick;
    logic [2:0]     rest;
    logic           last_piece;
    logic           out_load;
    fsre_pkg::sym_t pick_byte;

    logic           out_valid_reg;
    logic           out_valid_next;
    fsre_pkg::sym_t out_byte_reg;
    logic           out_last_reg;
    logic           out_done_reg;

    // Choose the earliest byte of the head entry not yet sent.
    always_comb
    begin
        pending[fsre_pkg::PIECE_CLOSE] = head_entry.has_close;
        pending[fsre_pkg::PIECE_LIT]   = head_entry.has_lit;
        pending[fsre_pkg::PIECE_ZERO]  = head_entry.has_zero;
        pending = pending & ~done_reg;
        pick    = pending & (~pending + 3'd1);
        rest    = pending & ~pick;
        last_piece = (rest == '0);
        if (pick[fsre_pkg::PIECE_CLOSE])
            pick_byte = head_entry.close_code;
        else if (pick[fsre_pkg::PIECE_LIT])
            pick_byte = head_entry.lit;
        else
            pick_byte = head_entry.zero_code;
    end

    assign out_load = head_valid && (!out_valid_reg || m_tready);
    assign head_pop = out_load && last_piece;

    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            done_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (out_load)
                done_reg <= last_piece ? 3'b000 : (done_reg | pick);
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_byte_reg <= pick_byte;
            out_last_reg <= last_piece;
            out_done_reg <= last_piece && head_entry.is_final;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_done_reg;

endmodule
